[hdl/mer_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and codes for the midpoint ellipse rasterizer: request kinds,
// datapath operation codes, and the command and status bundles.
// ----------------------------------------------------------------------------
package mer_pkg;

    // request kinds carried on the input tuser bit
    localparam logic OPC_START = 1'b0;
    localparam logic OPC_STEP  = 1'b1;

    // datapath operations, one per cycle
    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] dp_op_t;

    localparam dp_op_t OP_NONE      = 4'd0;
    localparam dp_op_t OP_LOAD      = 4'd1;
    localparam dp_op_t OP_MUL_RX    = 4'd2;
    localparam dp_op_t OP_MUL_RY    = 4'd3;
    localparam dp_op_t OP_MUL_PY    = 4'd4;
    localparam dp_op_t OP_INIT      = 4'd5;
    localparam dp_op_t OP_MUL_TX    = 4'd6;
    localparam dp_op_t OP_MUL_TY    = 4'd7;
    localparam dp_op_t OP_MUL_A     = 4'd8;
    localparam dp_op_t OP_MUL_B     = 4'd9;
    localparam dp_op_t OP_MUL_C     = 4'd10;
    localparam dp_op_t OP_SEED      = 4'd11;
    localparam dp_op_t OP_STEP1     = 4'd12;
    localparam dp_op_t OP_STEP2     = 4'd13;
    localparam dp_op_t OP_EMIT      = 4'd14;
    localparam dp_op_t OP_EMIT_NULL = 4'd15;

    // controller to datapath
    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic stay_r1;   // region one test holds for the current point
        logic in_r2;     // already walking region two
        logic active;    // an ellipse is in progress
        logic out_free;  // output register can take a result this cycle
    } dp_status_t;

endpackage : mer_pkg
`default_nettype wire

[hdl/midpoint_ellipse_rasterizer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core
// Midpoint ellipse rasterizer: a start request loads center and radii and
// returns the top point; each step request returns the next four symmetric
// points, region one then region two, flagging the point where y hits zero.
//
//   channel  dir  tdata                                   tuser        tlast
//   s_       in   center_x, center_y, radius_x, radius_y  opcode       -
//   m_       out  x_plus, x_minus, y_plus, y_minus        point_valid  last
//
// start request: load at the accept, three passes through the shared
// multiplier, the decision setup, then the result load
// step request: region test, one add step, result load; the step that
// leaves region one runs five multiplier passes and the seed load between
// the region test and its add step; a step with no ellipse in progress goes straight to a null result load
// one request at a time; s_tready is low while a request is worked on and
// returns the cycle after the result load
// a full output register holds the next result back until m_tready
// reset clears the controller, region and active flags and the output valid
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 11
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // center_x, center_y, radius_x, radius_y, zero fill
    input  wire [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_tdata,
    // opcode
    input  wire                                  s_tuser,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // x_plus, x_minus, y_plus, y_minus, zero fill
    output logic [((4*(COORD_BITS+1)+7)/8)*8-1:0] m_tdata,
    // point_valid
    output logic                                 m_tuser,
    output logic                                 m_tlast
);
    import mer_pkg::*;

    localparam int OUT_W  = COORD_BITS + 1;
    localparam int OUT_DW = ((4 * OUT_W + 7) / 8) * 8;

    dp_cmd_t    cmd;
    dp_status_t status;

    logic signed [COORD_BITS-1:0]  in_cx, in_cy;
    logic        [RADIUS_BITS-1:0] in_rx, in_ry;
    logic signed [OUT_W-1:0]       xp, xm, yp, ym;

    // unpack request fields
    assign in_cx = s_tdata[COORD_BITS-1:0];
    assign in_cy = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_rx = s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
    assign in_ry = s_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];

    mer_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_opcode (s_tuser),
        .req_ready  (s_tready),
        .status     (status),
        .cmd        (cmd)
    );

    mer_dpath #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_center_x     (in_cx),
        .in_center_y     (in_cy),
        .in_radius_x     (in_rx),
        .in_radius_y     (in_ry),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_point_valid (m_tuser),
        .out_x_plus      (xp),
        .out_x_minus     (xm),
        .out_y_plus      (yp),
        .out_y_minus     (ym),
        .out_last        (m_tlast)
    );

    // pack result fields
    assign m_tdata = OUT_DW'({ym, yp, xm, xp});

endmodule : midpoint_ellipse_rasterizer_core
`default_nettype wire

[hdl/mer_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_dpath
// Datapath: ellipse state, one shared registered multiplier, the incremental
// decision update for both regions and the output register.
// ----------------------------------------------------------------------------
module mer_dpath #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 11
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  mer_pkg::dp_cmd_t             cmd,
    output mer_pkg::dp_status_t          status,
    input  wire signed [COORD_BITS-1:0]  in_center_x,
    input  wire signed [COORD_BITS-1:0]  in_center_y,
    input  wire        [RADIUS_BITS-1:0] in_radius_x,
    input  wire        [RADIUS_BITS-1:0] in_radius_y,
    input  wire                          out_ready,
    output logic                         out_valid,
    output logic                         out_point_valid,
    output logic signed [COORD_BITS:0]   out_x_plus,
    output logic signed [COORD_BITS:0]   out_x_minus,
    output logic signed [COORD_BITS:0]   out_y_plus,
    output logic signed [COORD_BITS:0]   out_y_minus,
    output logic                         out_last
);
    import mer_pkg::*;

    localparam int R     = RADIUS_BITS;
    localparam int OUT_W = COORD_BITS + 1;
    localparam int XW    = R + 1;           // x offset with headroom
    localparam int SQ_W  = 2 * R;           // radius squared
    localparam int PY_W  = 3 * R;           // rx^2 * y
    localparam int PX_W  = 3 * R + 2;       // ry^2 * x
    localparam int MA_W  = 2 * R + 4;       // multiplier operand
    localparam int PW    = 2 * MA_W;        // multiplier product
    localparam int DEC_W = 4 * R + 10;      // decision, scaled by four
    localparam int SUM_W = (OUT_W > R + 3) ? OUT_W : R + 3;

    // ellipse state
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [R-1:0]     rx_reg, ry_reg;
    logic [SQ_W-1:0]  rx2_reg, ry2_reg;
    logic [XW-1:0]    x_reg;
    logic [R-1:0]     y_reg;
    logic [PX_W-1:0]  px_reg;
    logic [PY_W-1:0]  py_reg;
    logic signed [DEC_W-1:0] dec_reg, acc_reg;
    logic             r2_reg, active_reg;
    logic [PW-1:0]    prod_reg;
    logic [MA_W-1:0]  tmp_reg;

    // clamped radii
    logic [R-1:0] rx_clamp, ry_clamp;
    assign rx_clamp = (in_radius_x == '0) ? R'(1) : in_radius_x;
    assign ry_clamp = (in_radius_y == '0) ? R'(1) : in_radius_y;

    // region two seed terms
    logic [R+1:0] tx_val;
    logic [R:0]   ty_val;
    assign tx_val = {x_reg, 1'b1};
    assign ty_val = {y_reg, 1'b0} - (R + 1)'(1);

    // shared multiplier operand select
    logic [MA_W-1:0] mul_a, mul_b;
    logic            mul_en;
    logic [PW-1:0]   mul_p;
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (cmd.op)
            OP_MUL_RX: begin mul_a = MA_W'(rx_reg);  mul_b = MA_W'(rx_reg);  end
            OP_MUL_RY: begin mul_a = MA_W'(ry_reg);  mul_b = MA_W'(ry_reg);  end
            OP_MUL_PY: begin mul_a = MA_W'(rx2_reg); mul_b = MA_W'(ry_reg);  end
            OP_MUL_TX: begin mul_a = MA_W'(tx_val);  mul_b = MA_W'(tx_val);  end
            OP_MUL_TY: begin mul_a = MA_W'(ty_val);  mul_b = MA_W'(ty_val);  end
            OP_MUL_A:  begin mul_a = tmp_reg;        mul_b = MA_W'(ry2_reg); end
            OP_MUL_B:  begin mul_a = tmp_reg;        mul_b = MA_W'(rx2_reg); end
            OP_MUL_C:  begin mul_a = MA_W'(rx2_reg); mul_b = MA_W'(ry2_reg); end
            default:   mul_en = 1'b0;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // signed views for the decision arithmetic
    logic signed [DEC_W-1:0] rx2_s, ry2_s, px_s, py_s, prod_s;
    assign rx2_s  = DEC_W'(rx2_reg);
    assign ry2_s  = DEC_W'(ry2_reg);
    assign px_s   = DEC_W'(px_reg);
    assign py_s   = DEC_W'(py_reg);
    assign prod_s = DEC_W'(prod_reg);

    logic dec_neg, dec_pos;
    assign dec_neg = dec_reg[DEC_W-1];
    assign dec_pos = !dec_neg && (dec_reg != '0);

    // region one step: x always grows
    logic signed [DEC_W-1:0] dec_r1_base, dec_r1_down;
    assign dec_r1_base = dec_reg + (px_s <<< 3) + (ry2_s <<< 3) + (ry2_s <<< 2);
    assign dec_r1_down = dec_r1_base - (py_s <<< 3) + (rx2_s <<< 3);

    // region two step: y always drops
    logic signed [DEC_W-1:0] dec_r2_base, dec_r2_out;
    assign dec_r2_base = dec_reg + (rx2_s <<< 3) + (rx2_s <<< 2) - (py_s <<< 3);
    assign dec_r2_out  = dec_r2_base + (px_s <<< 3) + (ry2_s <<< 3);

    // four symmetric coordinates
    logic signed [SUM_W-1:0] cx_e, cy_e, x_e, y_e, xp_s, xm_s, yp_s, ym_s;
    assign cx_e = SUM_W'(cx_reg);
    assign cy_e = SUM_W'(cy_reg);
    assign x_e  = SUM_W'(x_reg);
    assign y_e  = SUM_W'(y_reg);
    assign xp_s = cx_e + x_e;
    assign xm_s = cx_e - x_e;
    assign yp_s = cy_e + y_e;
    assign ym_s = cy_e - y_e;

    // multiplier product register
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_p;
        end
    end

    // ellipse state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r2_reg     <= 1'b0;
            active_reg <= 1'b0;
        end else begin
            unique case (cmd.op)
                OP_LOAD: begin
                    cx_reg     <= in_center_x;
                    cy_reg     <= in_center_y;
                    rx_reg     <= rx_clamp;
                    ry_reg     <= ry_clamp;
                    x_reg      <= '0;
                    y_reg      <= ry_clamp;
                    px_reg     <= '0;
                    r2_reg     <= 1'b0;
                    active_reg <= 1'b1;
                end
                OP_MUL_RY: rx2_reg <= prod_reg[SQ_W-1:0];
                OP_MUL_PY: ry2_reg <= prod_reg[SQ_W-1:0];
                OP_INIT: begin
                    py_reg  <= prod_reg[PY_W-1:0];
                    dec_reg <= (ry2_s <<< 2) - (prod_s <<< 2) + rx2_s;
                end
                OP_MUL_TY: tmp_reg <= prod_reg[MA_W-1:0];
                OP_MUL_A:  tmp_reg <= prod_reg[MA_W-1:0];
                OP_MUL_B:  acc_reg <= prod_s;
                OP_MUL_C:  acc_reg <= acc_reg + prod_s;
                OP_SEED: begin
                    dec_reg <= acc_reg - (prod_s <<< 2);
                    r2_reg  <= 1'b1;
                end
                OP_STEP1: begin
                    x_reg  <= x_reg + XW'(1);
                    px_reg <= px_reg + PX_W'(ry2_reg);
                    if (dec_neg) begin
                        dec_reg <= dec_r1_base;
                    end else begin
                        y_reg   <= y_reg - R'(1);
                        py_reg  <= py_reg - PY_W'(rx2_reg);
                        dec_reg <= dec_r1_down;
                    end
                end
                OP_STEP2: begin
                    y_reg  <= y_reg - R'(1);
                    py_reg <= py_reg - PY_W'(rx2_reg);
                    if (dec_pos) begin
                        dec_reg <= dec_r2_base;
                    end else begin
                        x_reg   <= x_reg + XW'(1);
                        px_reg  <= px_reg + PX_W'(ry2_reg);
                        dec_reg <= dec_r2_out;
                    end
                end
                OP_EMIT: begin
                    if (y_reg == '0) begin
                        active_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (cmd.op == OP_EMIT || cmd.op == OP_EMIT_NULL) begin
            out_valid <= 1'b1;
        end else if (out_ready) begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT) begin
            out_point_valid <= 1'b1;
            out_x_plus      <= xp_s[OUT_W-1:0];
            out_x_minus     <= xm_s[OUT_W-1:0];
            out_y_plus      <= yp_s[OUT_W-1:0];
            out_y_minus     <= ym_s[OUT_W-1:0];
            out_last        <= (y_reg == '0);
        end else if (cmd.op == OP_EMIT_NULL) begin
            out_point_valid <= 1'b0;
            out_x_plus      <= '0;
            out_x_minus     <= '0;
            out_y_plus      <= '0;
            out_y_minus     <= '0;
            out_last        <= 1'b0;
        end
    end

    // status back to the controller
    assign status.stay_r1  = !r2_reg && (PX_W'(py_reg) >= px_reg);
    assign status.in_r2    = r2_reg;
    assign status.active   = active_reg;
    assign status.out_free = !out_valid || out_ready;

endmodule : mer_dpath
`default_nettype wire

[hdl/mer_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_ctrl
// Controller: accepts requests, sequences the multiplies for start and for
// the region two seed, picks the step kind and hands results to the output.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  req_valid,
    input  wire                  req_opcode,
    output logic                 req_ready,
    input  mer_pkg::dp_status_t  status,
    output mer_pkg::dp_cmd_t     cmd
);
    import mer_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MRX   = 4'd1;
    localparam logic [3:0] ST_MRY   = 4'd2;
    localparam logic [3:0] ST_MPY   = 4'd3;
    localparam logic [3:0] ST_INIT  = 4'd4;
    localparam logic [3:0] ST_TEST  = 4'd5;
    localparam logic [3:0] ST_TX    = 4'd6;
    localparam logic [3:0] ST_TY    = 4'd7;
    localparam logic [3:0] ST_MA    = 4'd8;
    localparam logic [3:0] ST_MB    = 4'd9;
    localparam logic [3:0] ST_MC    = 4'd10;
    localparam logic [3:0] ST_SEED  = 4'd11;
    localparam logic [3:0] ST_STEP1 = 4'd12;
    localparam logic [3:0] ST_STEP2 = 4'd13;
    localparam logic [3:0] ST_EMIT  = 4'd14;
    localparam logic [3:0] ST_NULL  = 4'd15;

    logic [3:0] state_reg, state_next;

    // next state and command
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    if (req_opcode == OPC_START) begin
                        cmd.op     = OP_LOAD;
                        state_next = ST_MRX;
                    end else if (status.active) begin
                        state_next = ST_TEST;
                    end else begin
                        state_next = ST_NULL;
                    end
                end
            end
            ST_MRX: begin cmd.op = OP_MUL_RX; state_next = ST_MRY;  end
            ST_MRY: begin cmd.op = OP_MUL_RY; state_next = ST_MPY;  end
            ST_MPY: begin cmd.op = OP_MUL_PY; state_next = ST_INIT; end
            ST_INIT: begin cmd.op = OP_INIT;  state_next = ST_EMIT; end
            ST_TEST: begin
                if (status.stay_r1) begin
                    state_next = ST_STEP1;
                end else if (status.in_r2) begin
                    state_next = ST_STEP2;
                end else begin
                    state_next = ST_TX;
                end
            end
            ST_TX:    begin cmd.op = OP_MUL_TX; state_next = ST_TY;    end
            ST_TY:    begin cmd.op = OP_MUL_TY; state_next = ST_MA;    end
            ST_MA:    begin cmd.op = OP_MUL_A;  state_next = ST_MB;    end
            ST_MB:    begin cmd.op = OP_MUL_B;  state_next = ST_MC;    end
            ST_MC:    begin cmd.op = OP_MUL_C;  state_next = ST_SEED;  end
            ST_SEED:  begin cmd.op = OP_SEED;   state_next = ST_STEP2; end
            ST_STEP1: begin cmd.op = OP_STEP1;  state_next = ST_EMIT;  end
            ST_STEP2: begin cmd.op = OP_STEP2;  state_next = ST_EMIT;  end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            ST_NULL: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT_NULL;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule : mer_ctrl
`default_nettype wire
